### hdl/smac_pkg.sv
package smac_pkg;

    // Channel count and field widths
    localparam int NUM_CH     = 4;
    localparam int ADC_W      = 12;
    localparam int OFS_W      = 10;
    localparam int CMD_W      = 11;
    localparam int SAMPLE_W   = 12;
    localparam int SCALED_W   = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int WINDOW_DEF = 10;

    // Channel order, shared by the offset registers and the lanes
    localparam int CH_THROTTLE = 0;
    localparam int CH_YAW      = 1;
    localparam int CH_PITCH    = 2;
    localparam int CH_ROLL     = 3;

    // Scale by 2441/10000: ceil(0.2441 * 2^28), exact floor for every 12-bit sample
    localparam int                         SCALE_MUL_W = 26;
    localparam int                         SCALE_SHIFT = 28;
    localparam logic [SCALE_MUL_W-1:0]     SCALE_MUL   = 26'd65525095;

    // Command shaping
    localparam int BASE_VALUE  = 1000;
    localparam int OUT_MIN     = 1000;
    localparam int OUT_MAX     = 2000;
    localparam int DEAD_LOW    = 1490;
    localparam int DEAD_HIGH   = 1510;
    localparam int DEAD_CENTRE = 1500;
    localparam int SAMPLE_MAX  = 2510;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_THROTTLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_YAW      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_PITCH    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFS_ROLL     = 4'd3;

    // Load enables for the lane pipeline stages
    typedef struct packed {
        logic sample;   // input register -> sample register
        logic ring;     // sample enters the window, sum is captured
        logic cmd;      // mean -> command register
    } t_stage_en;

endpackage

### hdl/smac_lane.sv
module smac_lane #(
    parameter int WINDOW = smac_pkg::WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smac_pkg::t_stage_en                i_en,
    input  logic        [smac_pkg::ADC_W-1:0]  i_adc,
    input  logic signed [smac_pkg::OFS_W-1:0]  i_offset,
    output logic        [smac_pkg::CMD_W-1:0]  o_cmd
);
    import smac_pkg::*;

    localparam int SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int SUM_X_W   = SUM_W + 1;
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MUL_W     = SUM_W + 2;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam int ADC_P_W   = ADC_W + SCALE_MUL_W;
    localparam int SMP_X_W   = SAMPLE_W + 1;

    localparam logic [MUL_W-1:0] DIV_MUL_V = MUL_W'(DIV_MUL);

    logic [ADC_P_W-1:0]  scale_prod;
    logic [SCALED_W-1:0] scaled;
    logic [SMP_X_W-1:0]  sample_x;
    logic [SAMPLE_W-1:0] n_sample;
    logic [SAMPLE_W-1:0] r_sample;

    logic [SAMPLE_W-1:0] r_hist [WINDOW];
    logic [SUM_X_W-1:0]  sum_x;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_sum_q;

    logic [PROD_W-1:0]   div_prod;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] clamped;
    logic [CMD_W-1:0]    n_cmd;
    logic [CMD_W-1:0]    r_cmd;

    // Scale, add base and sign-extended offset (result always in 488..2510)
    always_comb begin
        scale_prod = ADC_P_W'(i_adc) * ADC_P_W'(SCALE_MUL);
        scaled     = scale_prod[SCALE_SHIFT +: SCALED_W];
        sample_x   = SMP_X_W'(scaled) + SMP_X_W'(BASE_VALUE)
                   + {{(SMP_X_W - OFS_W){i_offset[OFS_W-1]}}, i_offset};
        n_sample   = sample_x[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sample) begin
            r_sample <= n_sample;
        end
    end

    // Running sum: drop the oldest tap, add the new sample
    always_comb begin
        sum_x = {1'b0, r_sum} - SUM_X_W'(r_hist[WINDOW-1]) + SUM_X_W'(r_sample);
        n_sum = sum_x[SUM_W-1:0];
    end

    // Window history as a shift line, zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_en.ring) begin
            r_sum     <= n_sum;
            r_hist[0] <= r_sample;
            for (int i = 1; i < WINDOW; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ring) begin
            r_sum_q <= n_sum;
        end
    end

    // Mean by reciprocal multiply, then clamp and deadband
    always_comb begin
        div_prod = PROD_W'(r_sum_q) * PROD_W'(DIV_MUL_V);
        mean     = div_prod[DIV_SHIFT +: SAMPLE_W];
        if (mean > SAMPLE_W'(OUT_MAX)) begin
            clamped = SAMPLE_W'(OUT_MAX);
        end else if (mean < SAMPLE_W'(OUT_MIN)) begin
            clamped = SAMPLE_W'(OUT_MIN);
        end else begin
            clamped = mean;
        end
        if (clamped > SAMPLE_W'(DEAD_LOW) && clamped < SAMPLE_W'(DEAD_HIGH)) begin
            n_cmd = CMD_W'(DEAD_CENTRE);
        end else begin
            n_cmd = clamped[CMD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.cmd) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

endmodule

### hdl/stick_moving_average_conditioner.sv
// Stages are input, sample, window sum and command; each is a register on the path to the output.
// Throughput: one transaction per cycle while the output is not stalled.
// The stage chain stalls only when the output register holds a result not yet taken.
// Reset (synchronous, active low) zeroes the window history, running sum, offsets and valids.
// Configuration writes are always accepted (ready is always high).
module stick_moving_average_conditioner #(
    parameter int WINDOW = smac_pkg::WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [smac_pkg::ADC_W-1:0]           i_adc_throttle,
    input  logic [smac_pkg::ADC_W-1:0]           i_adc_yaw,
    input  logic [smac_pkg::ADC_W-1:0]           i_adc_pitch,
    input  logic [smac_pkg::ADC_W-1:0]           i_adc_roll,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [smac_pkg::CMD_W-1:0]           o_throttle,
    output logic [smac_pkg::CMD_W-1:0]           o_yaw,
    output logic [smac_pkg::CMD_W-1:0]           o_pitch,
    output logic [smac_pkg::CMD_W-1:0]           o_roll,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [smac_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smac_pkg::OFS_W-1:0]           i_cfg_data
);
    import smac_pkg::*;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic              s1_ready, s2_ready, s3_ready, s4_ready;
    t_stage_en         stage_en;
    logic [ADC_W-1:0]  r_adc    [NUM_CH];
    logic [OFS_W-1:0]  r_offset [NUM_CH];
    logic [CMD_W-1:0]  cmd      [NUM_CH];

    // Ready chain: a stage moves when the next one is empty or moving
    assign s4_ready = !r_v4 || i_out_ready;
    assign s3_ready = !r_v3 || s4_ready;
    assign s2_ready = !r_v2 || s3_ready;
    assign s1_ready = !r_v1 || s2_ready;

    assign stage_en.sample = r_v1 && s2_ready;
    assign stage_en.ring   = r_v2 && s3_ready;
    assign stage_en.cmd    = r_v3 && s4_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_ready) r_v1 <= i_in_valid;
            if (s2_ready) r_v2 <= r_v1;
            if (s3_ready) r_v3 <= r_v2;
            if (s4_ready) r_v4 <= r_v3;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && s1_ready) begin
            r_adc[CH_THROTTLE] <= i_adc_throttle;
            r_adc[CH_YAW]      <= i_adc_yaw;
            r_adc[CH_PITCH]    <= i_adc_pitch;
            r_adc[CH_ROLL]     <= i_adc_roll;
        end
    end

    // Offset registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_offset[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFS_THROTTLE: r_offset[CH_THROTTLE] <= i_cfg_data;
                CFG_OFS_YAW:      r_offset[CH_YAW]      <= i_cfg_data;
                CFG_OFS_PITCH:    r_offset[CH_PITCH]    <= i_cfg_data;
                CFG_OFS_ROLL:     r_offset[CH_ROLL]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One lane per stick channel
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        smac_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (stage_en),
            .i_adc    (r_adc[c]),
            .i_offset ($signed(r_offset[c])),
            .o_cmd    (cmd[c])
        );
    end

    assign o_in_ready  = s1_ready;
    assign o_out_valid = r_v4;
    assign o_cfg_ready = 1'b1;
    assign o_throttle  = cmd[CH_THROTTLE];
    assign o_yaw       = cmd[CH_YAW];
    assign o_pitch     = cmd[CH_PITCH];
    assign o_roll      = cmd[CH_ROLL];

endmodule

### hdl/smac_checker.sv
module smac_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [smac_pkg::CMD_W-1:0]     o_throttle,
    input logic [smac_pkg::CMD_W-1:0]     o_yaw,
    input logic [smac_pkg::CMD_W-1:0]     o_pitch,
    input logic [smac_pkg::CMD_W-1:0]     o_roll
);
    import smac_pkg::*;

    localparam logic [CMD_W-1:0] MIN_V  = CMD_W'(OUT_MIN);
    localparam logic [CMD_W-1:0] MAX_V  = CMD_W'(OUT_MAX);
    localparam logic [CMD_W-1:0] DLO_V  = CMD_W'(DEAD_LOW);
    localparam logic [CMD_W-1:0] DHI_V  = CMD_W'(DEAD_HIGH);
    localparam logic [CMD_W-1:0] CTR_V  = CMD_W'(DEAD_CENTRE);

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_throttle) && $stable(o_yaw)
            && $stable(o_pitch) && $stable(o_roll))
        else $error("stalled result changed");

    // Commands stay inside the clamp range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_throttle >= MIN_V && o_throttle <= MAX_V
            && o_yaw >= MIN_V && o_yaw <= MAX_V
            && o_pitch >= MIN_V && o_pitch <= MAX_V
            && o_roll >= MIN_V && o_roll <= MAX_V)
        else $error("command outside clamp range");

    // Inside the deadband only the centre value appears
    a_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_throttle <= DLO_V || o_throttle >= DHI_V || o_throttle == CTR_V)
            && (o_yaw <= DLO_V || o_yaw >= DHI_V || o_yaw == CTR_V)
            && (o_pitch <= DLO_V || o_pitch >= DHI_V || o_pitch == CTR_V)
            && (o_roll <= DLO_V || o_roll >= DHI_V || o_roll == CTR_V))
        else $error("command inside deadband not centred");

endmodule

bind stick_moving_average_conditioner smac_checker u_smac_checker (.*);

### dv/stick_moving_average_conditioner_checker.sv
`timescale 1ns / 100ps

// Watches the input, output and register-write channels of the stick conditioner,
// predicts each command from the accepted ADC scan and compares in order.
module stick_moving_average_conditioner_checker #(
    parameter int WINDOW = smac_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [smac_pkg::ADC_W-1:0]     i_adc_throttle,
    input  logic [smac_pkg::ADC_W-1:0]     i_adc_yaw,
    input  logic [smac_pkg::ADC_W-1:0]     i_adc_pitch,
    input  logic [smac_pkg::ADC_W-1:0]     i_adc_roll,
    // output channel
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [smac_pkg::CMD_W-1:0]     i_throttle,
    input  logic [smac_pkg::CMD_W-1:0]     i_yaw,
    input  logic [smac_pkg::CMD_W-1:0]     i_pitch,
    input  logic [smac_pkg::CMD_W-1:0]     i_roll,
    // register writes
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [smac_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [smac_pkg::OFS_W-1:0]     i_cfg_data,
    // end of run: anything still queued is a failure
    input  logic                           i_end_check,
    output int                             o_pending,
    output int                             o_fail_count
);
    import smac_pkg::*;

    // Own copy of the shaping constants
    localparam int SCALE_NUM  = 2441;
    localparam int SCALE_DEN  = 10000;
    localparam int LEVEL_BASE = 1000;
    localparam int CMD_FLOOR  = 1000;
    localparam int CMD_CEIL   = 2000;
    localparam int BAND_LOW   = 1490;
    localparam int BAND_HIGH  = 1510;
    localparam int BAND_SNAP  = 1500;
    localparam int SUM_W      = 18;   // 64 slots of 4095 never wrap

    typedef struct packed {
        logic [CMD_W-1:0] throttle;
        logic [CMD_W-1:0] yaw;
        logic [CMD_W-1:0] pitch;
        logic [CMD_W-1:0] roll;
    } t_command;

    // Predictor state
    logic signed [OFS_W-1:0]    offset     [NUM_CH];
    logic        [SAMPLE_W-1:0] history    [NUM_CH][WINDOW];
    logic        [SUM_W-1:0]    window_sum [NUM_CH];
    int unsigned                slot;
    t_command                   pending_commands[$];
    logic                       end_done;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        end_done     = 1'b0;
    end

    // One channel through scale, offset, ring average, clamp and deadband
    function automatic logic [CMD_W-1:0] filter_channel(input int ch,
                                                        input logic [ADC_W-1:0] adc);
        int unsigned         scaled;
        int                  level;
        int unsigned         mean;
        logic [SAMPLE_W-1:0] level_bits;
        scaled     = (int'(adc) * SCALE_NUM) / SCALE_DEN;
        level      = int'(scaled) + LEVEL_BASE + int'(offset[ch]);
        level_bits = level[SAMPLE_W-1:0];
        window_sum[ch]    = window_sum[ch] - history[ch][slot] + level_bits;
        history[ch][slot] = level_bits;
        mean = window_sum[ch] / WINDOW;
        if (mean > CMD_CEIL)
            mean = CMD_CEIL;
        if (mean < CMD_FLOOR)
            mean = CMD_FLOOR;
        if (mean > BAND_LOW && mean < BAND_HIGH)
            mean = BAND_SNAP;
        return mean[CMD_W-1:0];
    endfunction

    // Reports one field; returns 1 on mismatch
    function automatic int check_field(input string field, input logic [CMD_W-1:0] want,
                                       input logic [CMD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_command want;
        int       bad;
        if (!i_rst_n) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                offset[ch]     = '0;
                window_sum[ch] = '0;
                for (int s = 0; s < WINDOW; s++)
                    history[ch][s] = '0;
            end
            slot = 0;
            pending_commands.delete();
        end else begin
            // Register write; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OFS_THROTTLE: offset[CH_THROTTLE] = i_cfg_data;
                    CFG_OFS_YAW:      offset[CH_YAW]      = i_cfg_data;
                    CFG_OFS_PITCH:    offset[CH_PITCH]    = i_cfg_data;
                    CFG_OFS_ROLL:     offset[CH_ROLL]     = i_cfg_data;
                    default: ;
                endcase
            end

            // Accepted scan: predict its command, advance the shared ring slot
            if (i_in_valid && i_in_ready) begin
                want.throttle = filter_channel(CH_THROTTLE, i_adc_throttle);
                want.yaw      = filter_channel(CH_YAW, i_adc_yaw);
                want.pitch    = filter_channel(CH_PITCH, i_adc_pitch);
                want.roll     = filter_channel(CH_ROLL, i_adc_roll);
                slot = (slot == WINDOW - 1) ? 0 : slot + 1;
                pending_commands.push_back(want);
            end

            // Accepted command: compare with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pending_commands.size() == 0) begin
                    $error("command %0d/%0d/%0d/%0d with no prediction queued",
                           i_throttle, i_yaw, i_pitch, i_roll);
                    o_fail_count++;
                end else begin
                    want = pending_commands.pop_front();
                    bad  = check_field("throttle", want.throttle, i_throttle)
                         + check_field("yaw", want.yaw, i_yaw)
                         + check_field("pitch", want.pitch, i_pitch)
                         + check_field("roll", want.roll, i_roll);
                    if (bad != 0)
                        o_fail_count++;
                end
            end

            // Leftover predictions at the end
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (pending_commands.size() != 0) begin
                    $error("%0d predicted commands never came out", pending_commands.size());
                    o_fail_count++;
                end
            end
        end
        o_pending = pending_commands.size();
    end

endmodule

### dv/stick_moving_average_conditioner_tb.sv
`timescale 1ns / 100ps

module stick_moving_average_conditioner_tb;
    import smac_pkg::*;

    localparam int WINDOW         = WINDOW_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 222;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CFG_TOP_INDEX  = 15;
    localparam int ADC_MID_LOW    = 1990;   // scans that land near the deadband
    localparam int ADC_MID_HIGH   = 2110;
    localparam int ADC_CENTRE     = 2049;   // scales to exactly 500
    localparam time TIMEOUT_NS    = 10_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ADC_W-1:0]     i_adc_throttle;
    logic [ADC_W-1:0]     i_adc_yaw;
    logic [ADC_W-1:0]     i_adc_pitch;
    logic [ADC_W-1:0]     i_adc_roll;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CMD_W-1:0]     o_throttle;
    logic [CMD_W-1:0]     o_yaw;
    logic [CMD_W-1:0]     o_pitch;
    logic [CMD_W-1:0]     o_roll;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [OFS_W-1:0]     i_cfg_data;

    logic end_check;
    int   pending;
    int   fail_count;

    // Traffic shaping controls
    logic tx_no_idle;
    logic rx_no_stall;
    logic rx_hold_req;

    stick_moving_average_conditioner #(
        .WINDOW (WINDOW)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_adc_throttle (i_adc_throttle),
        .i_adc_yaw      (i_adc_yaw),
        .i_adc_pitch    (i_adc_pitch),
        .i_adc_roll     (i_adc_roll),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_throttle     (o_throttle),
        .o_yaw          (o_yaw),
        .o_pitch        (o_pitch),
        .o_roll         (o_roll),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    stick_moving_average_conditioner_checker #(
        .WINDOW (WINDOW)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_adc_throttle (i_adc_throttle),
        .i_adc_yaw      (i_adc_yaw),
        .i_adc_pitch    (i_adc_pitch),
        .i_adc_roll     (i_adc_roll),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_throttle     (o_throttle),
        .i_yaw          (o_yaw),
        .i_pitch        (o_pitch),
        .i_roll         (o_roll),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_end_check    (end_check),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one scan and hold it until the transaction completes
    task automatic send_scan(input logic [ADC_W-1:0] thr, input logic [ADC_W-1:0] yaw,
                             input logic [ADC_W-1:0] pit, input logic [ADC_W-1:0] rol);
        int   gap;
        logic took;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_adc_throttle <= thr;
        i_adc_yaw      <= yaw;
        i_adc_pitch    <= pit;
        i_adc_roll     <= rol;
        do begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Stop offering and wait until every predicted command has come out
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // One register write; valid is left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] data);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // All four offsets, with a write to an unused index in the middle
    task automatic program_offsets(input logic signed [OFS_W-1:0] thr,
                                   input logic signed [OFS_W-1:0] yaw,
                                   input logic signed [OFS_W-1:0] pit,
                                   input logic signed [OFS_W-1:0] rol);
        write_reg(CFG_OFS_THROTTLE, thr);
        write_reg(CFG_OFS_YAW, yaw);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_OFS_ROLL) + 1, CFG_TOP_INDEX)),
                  OFS_W'($urandom_range(0, 1023)));
        write_reg(CFG_OFS_PITCH, pit);
        write_reg(CFG_OFS_ROLL, rol);
        i_cfg_valid <= 1'b0;
    endtask

    // Offset for a channel in a given phase: extremes, zero, small and full random
    function automatic int pick_offset(input int phase, input int ch);
        case (phase)
            0:       return -512;
            1:       return 511;
            4:       return (ch % 2 == 0) ? -512 : 511;
            5:       return 0;
            2, 7:    return int'($urandom_range(0, 40)) - 20;
            default: return int'($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    function automatic logic [ADC_W-1:0] pick_adc(input int kind);
        if (kind >= 7 && kind <= 8)
            return ADC_W'($urandom_range(ADC_MID_LOW, ADC_MID_HIGH));
        if (kind == 9)
            return $urandom_range(0, 1) ? {ADC_W{1'b1}} : '0;
        return ADC_W'($urandom_range(0, 4095));
    endfunction

    // Random scans in runs: noise, held sticks, near-centre, and full-scale slams
    task automatic run_random(input int count);
        logic [ADC_W-1:0] adc [NUM_CH];
        int               kind;
        int               run_left;
        logic             fresh;
        run_left = 0;
        kind     = 0;
        for (int n = 0; n < count; n++) begin
            fresh = 1'b0;
            if (run_left == 0) begin
                kind     = $urandom_range(0, 9);
                run_left = $urandom_range(1, 3 * WINDOW);
                fresh    = 1'b1;
            end
            // kinds 4..6 hold one scan for the whole run
            if (fresh || kind < 4 || kind > 6)
                for (int ch = 0; ch < NUM_CH; ch++)
                    adc[ch] = pick_adc(kind);
            run_left--;
            send_scan(adc[CH_THROTTLE], adc[CH_YAW], adc[CH_PITCH], adc[CH_ROLL]);
            if ($urandom_range(0, 299) == 0)
                wait_drain();
        end
    endtask

    // Receiver: random stalls, a no-stall mode, and a long hold-off on request
    initial begin : receiver
        int burst;
        int idle;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < RX_HOLD_CYCLES; c++)
                    @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_no_stall) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 6);
                idle  = pick_gap();
                i_out_ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
                if (idle > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (idle) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_adc_throttle = '0;
        i_adc_yaw      = '0;
        i_adc_pitch    = '0;
        i_adc_roll     = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        end_check      = 1'b0;
        tx_no_idle     = 1'b0;
        rx_no_stall    = 1'b0;
        rx_hold_req    = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Warm-up from the zeroed ring with reset offsets, full-scale and bit patterns
        send_scan(12'h000, 12'hFFF, 12'hAAA, 12'h555);
        send_scan(12'hFFF, 12'h000, 12'h555, 12'hAAA);
        send_scan(12'h000, 12'h000, 12'h000, 12'h000);
        send_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Steady centred sticks, offsets put the means on both deadband edges
        program_offsets(OFS_W'(-10), OFS_W'(-9), OFS_W'(9), OFS_W'(10));
        for (int n = 0; n < WINDOW + 2; n++)
            send_scan(ADC_W'(ADC_CENTRE), ADC_W'(ADC_CENTRE), ADC_W'(ADC_CENTRE),
                      ADC_W'(ADC_CENTRE));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            program_offsets(OFS_W'(pick_offset(phase, CH_THROTTLE)),
                            OFS_W'(pick_offset(phase, CH_YAW)),
                            OFS_W'(pick_offset(phase, CH_PITCH)),
                            OFS_W'(pick_offset(phase, CH_ROLL)));
            case (phase)
                2: begin
                    // Output blocked for a long stretch while scans keep coming
                    run_random(PHASE_ITEMS / 2);
                    rx_hold_req = 1'b1;
                    tx_no_idle  = 1'b1;
                    run_random(40);
                    tx_no_idle  = 1'b0;
                    run_random(PHASE_ITEMS / 2 - 40);
                end
                3: begin
                    run_random(PHASE_ITEMS / 2);
                    wait_drain();
                    run_random(PHASE_ITEMS / 2);
                end
                5: begin
                    // Back-to-back on both sides
                    tx_no_idle  = 1'b1;
                    rx_no_stall = 1'b1;
                    run_random(PHASE_ITEMS);
                    tx_no_idle  = 1'b0;
                    rx_no_stall = 1'b0;
                end
                default: run_random(PHASE_ITEMS);
            endcase
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("stick_moving_average_conditioner: match");
        else
            $display("stick_moving_average_conditioner: mismatch");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("stick_moving_average_conditioner: mismatch");
        $finish;
    end

endmodule
